// ===== hdl/equirect_to_cubemap_sampler_core_defines.svh =====
// Assertion macros for the equirectangular to cube map sampler.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef EQUIRECT_TO_CUBEMAP_SAMPLER_CORE_DEFINES_SVH
`define EQUIRECT_TO_CUBEMAP_SAMPLER_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define EQC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eqc check failed");

// Antecedent implies consequent in the next cycle.
`define EQC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eqc check failed");

`endif

// ===== hdl/eqc_pkg.sv =====
// Shared constants, types and tables for the cube map sampler.
// Depends on nothing; imported by the CORDIC unit, image memory and top level.
package eqc_pkg;

    localparam int DW          = 32;
    localparam int SRC_W_W     = 9;
    localparam int SRC_H_W     = 8;
    localparam int FS_W        = 7;
    localparam int DIR_SHIFT   = 20;
    localparam int ATAN_ENTRIES = 24;
    localparam int ACC_W       = 25;

    localparam int DEF_MAX_SRC_WIDTH  = 256;
    localparam int DEF_MAX_SRC_HEIGHT = 128;
    localparam int DEF_CORDIC_STEPS   = 16;

    localparam logic signed [DW-1:0] ANG_PI      = 32'sd1073741824;
    localparam logic signed [DW-1:0] ANG_HALF_PI = 32'sd536870912;
    localparam logic [15:0]          INV_GAIN    = 16'd39797;

    localparam logic [SRC_W_W-1:0] RST_SRC_WIDTH  = 9'd256;
    localparam logic [SRC_H_W-1:0] RST_SRC_HEIGHT = 8'd128;

    localparam logic CFG_SRC_WIDTH  = 1'b0;
    localparam logic CFG_SRC_HEIGHT = 1'b1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } eqc_cordic_stat_t;

    function automatic logic signed [DW-1:0] atan_entry(input logic [4:0] k);
        logic signed [DW-1:0] v;
        case (k)
            5'd0:  v = 32'sd268435456;
            5'd1:  v = 32'sd158466703;
            5'd2:  v = 32'sd83729454;
            5'd3:  v = 32'sd42502380;
            5'd4:  v = 32'sd21333666;
            5'd5:  v = 32'sd10677233;
            5'd6:  v = 32'sd5339919;
            5'd7:  v = 32'sd2670123;
            5'd8:  v = 32'sd1335082;
            5'd9:  v = 32'sd667543;
            5'd10: v = 32'sd333772;
            5'd11: v = 32'sd166886;
            5'd12: v = 32'sd83443;
            5'd13: v = 32'sd41722;
            5'd14: v = 32'sd20861;
            5'd15: v = 32'sd10430;
            5'd16: v = 32'sd5215;
            5'd17: v = 32'sd2608;
            5'd18: v = 32'sd1304;
            5'd19: v = 32'sd652;
            5'd20: v = 32'sd326;
            5'd21: v = 32'sd163;
            5'd22: v = 32'sd81;
            5'd23: v = 32'sd41;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] face_off_x(input logic [2:0] f);
        logic [1:0] v;
        case (f)
            3'd1:    v = 2'd0;
            3'd3:    v = 2'd2;
            default: v = 2'd1;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] face_off_y(input logic [2:0] f);
        logic [1:0] v;
        case (f)
            3'd0:    v = 2'd3;
            3'd4:    v = 2'd0;
            3'd5:    v = 2'd2;
            default: v = 2'd1;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/eqc_cordic.sv =====
// Iterative CORDIC vectoring unit: angle of (x,y) and scaled magnitude.
// Depends on eqc_pkg for the arctangent table and status struct.
module eqc_cordic
    import eqc_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    output eqc_cordic_stat_t     stat,
    output logic signed [DW-1:0] z_out,
    output logic signed [DW-1:0] mag_out
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int KW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    logic signed [DW-1:0] x_reg, y_reg, z_reg;
    logic [KW-1:0]        k_reg;
    logic                 busy_reg, done_reg;
    logic signed [DW-1:0] dx, dy, at;

    assign dx = y_reg >>> k_reg;
    assign dy = x_reg >>> k_reg;
    assign at = atan_entry(5'(k_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            k_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
                if (x_in < 0)
                begin
                    if (y_in >= 0)
                    begin
                        x_reg <= y_in;
                        y_reg <= -x_in;
                        z_reg <= ANG_HALF_PI;
                    end
                    else
                    begin
                        x_reg <= -y_in;
                        y_reg <= x_in;
                        z_reg <= -ANG_HALF_PI;
                    end
                end
                else
                begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= '0;
                end
            end
            else if (busy_reg)
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                else if (y_reg < 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                if (k_reg == KW'(NSTEP - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign z_out     = z_reg;
    assign mag_out   = (x_reg < 0) ? '0 : x_reg;

endmodule

// ===== hdl/eqc_image_mem.sv =====
// Source image store: one write port, one read port, registered read data.
// Depends on eqc_pkg for the word width.
module eqc_image_mem
    import eqc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT,
    parameter int AW    = $clog2(DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] pix_mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pix_mem[waddr] <= wdata;
        end
        rdata_reg <= pix_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/equirect_to_cubemap_sampler_core.sv =====
// Top level of the equirectangular to vertical-cross cube map sampler.
// Depends on eqc_pkg, eqc_cordic, eqc_image_mem and the assertion macro header.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------------------
//   in       | sink      | in_valid / in_stall | action src_x src_y src_pixel face face_i face_j
//   out      | source    | out_valid/out_stall | cross_x cross_y color
//   cfg      | sink      | cfg_valid/cfg_ready | cfg_index cfg_data
//
// A load beat does not stall the input. A sample beat passes through VEC1, WAIT1,
// SCALE, VEC2, WAIT2, MAPU, MAPV, CLAMP, FETCH and OUT to the result register,
// and the next beat is accepted once the state is back in IDLE; the run is set by
// the two passes through the one CORDIC unit and the four texel reads from the
// single read port. in_stall is high while a sample is in flight. The result
// register holds a beat under out_stall; a finished sample waits for it to free.
// Reset clears all control state; the image store is not cleared.
`include "equirect_to_cubemap_sampler_core_defines.svh"

module equirect_to_cubemap_sampler_core
    import eqc_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
    parameter int CORDIC_STEPS   = DEF_CORDIC_STEPS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [7:0]         src_x,
    input  logic [6:0]         src_y,
    input  logic [31:0]        src_pixel,
    input  logic [2:0]         face,
    input  logic [5:0]         face_i,
    input  logic [5:0]         face_j,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         cross_x,
    output logic [7:0]         cross_y,
    output logic [31:0]        color,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [SRC_W_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_VEC1, ST_WAIT1, ST_SCALE, ST_VEC2, ST_WAIT2,
        ST_MAPU, ST_MAPV, ST_CLAMP, ST_FETCH, ST_OUT
    } state_t;

    state_t               state_reg;
    logic [SRC_W_W-1:0]   wcfg_reg;
    logic [SRC_H_W-1:0]   hcfg_reg;
    logic [SRC_W_W-1:0]   w_eff, w_reg;
    logic [SRC_H_W-1:0]   h_eff, h_reg;
    logic [FS_W-1:0]      fs_eff, fs_reg;
    logic [2:0]           face_reg;
    logic [5:0]           fi_reg, fj_reg;
    logic signed [8:0]    da, db, dofs;
    logic signed [8:0]    px_s, py_s, pz_s;
    logic signed [DW-1:0] px_reg, py_reg, pz_reg, r_reg;
    logic signed [DW-1:0] theta_reg, phi_reg, theta_sat, phi_sat;
    logic [17:0]          uq_reg, vq_reg;
    logic [SRC_W_W-1:0]   u1_reg, u2_reg;
    logic [SRC_H_W-1:0]   v1_reg, v2_reg;
    logic [8:0]           s_reg, t_reg;
    logic [2:0]           cnt_reg;
    logic                 pend_reg;
    logic [16:0]          wgt_reg, wgt_next;
    logic [ACC_W-1:0]     acc_reg [4];
    logic                 out_valid_reg;
    logic [7:0]           cross_x_reg, cross_y_reg;
    logic [31:0]          color_reg, color_next;
    logic                 accept, sample_ok, mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [DW-1:0]        mem_rdata;
    logic                 cord_start;
    logic signed [DW-1:0] cord_x, cord_y, cord_z, cord_mag;
    eqc_cordic_stat_t     cord_stat;
    logic [47:0]          scale_prod;
    logic [DW-1:0]        theta_off, phi_off;
    logic [38:0]          map_prod;
    logic [9:0]           u_int, v_int;
    logic [SRC_W_W-1:0]   u1_c, u2_c;
    logic [SRC_H_W-1:0]   v1_c, v2_c;
    logic [17:0]          s_diff, t_diff;
    logic [8:0]           ws, wt;
    logic [8:0]           cx_sum, cy_sum;

    always_comb
    begin
        if (int'(wcfg_reg) < 4)
            w_eff = SRC_W_W'(4);
        else if (int'(wcfg_reg) > MAX_SRC_WIDTH)
            w_eff = SRC_W_W'(MAX_SRC_WIDTH);
        else
            w_eff = wcfg_reg;
        if (int'(hcfg_reg) < 1)
            h_eff = SRC_H_W'(1);
        else if (int'(hcfg_reg) > MAX_SRC_HEIGHT)
            h_eff = SRC_H_W'(MAX_SRC_HEIGHT);
        else
            h_eff = hcfg_reg;
    end

    assign fs_eff    = w_eff[SRC_W_W-1:2];
    assign sample_ok = (face <= 3'd5) && ({1'b0, face_i} < fs_eff) && ({1'b0, face_j} < fs_eff);
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign da   = $signed({2'b00, face_i, 1'b0}) - $signed({2'b00, fs_eff});
    assign db   = $signed({2'b00, face_j, 1'b0}) - $signed({2'b00, fs_eff});
    assign dofs = $signed({2'b00, fs_eff});

    always_comb
    begin
        case (face)
            3'd0:
            begin
                px_s = -dofs; py_s = da;    pz_s = db;
            end
            3'd1:
            begin
                px_s = da;    py_s = -dofs; pz_s = -db;
            end
            3'd2:
            begin
                px_s = dofs;  py_s = da;    pz_s = -db;
            end
            3'd3:
            begin
                px_s = -da;   py_s = dofs;  pz_s = -db;
            end
            3'd4:
            begin
                px_s = db;    py_s = da;    pz_s = dofs;
            end
            default:
            begin
                px_s = -db;   py_s = da;    pz_s = -dofs;
            end
        endcase
    end

    assign mem_we    = accept && (action == ACT_LOAD) && (int'(src_x) < MAX_SRC_WIDTH)
                       && (int'(src_y) < MAX_SRC_HEIGHT);
    assign mem_waddr = AW'(int'(src_y) * MAX_SRC_WIDTH + int'(src_x));
    assign mem_raddr = AW'(int'(cnt_reg[1] ? v2_reg : v1_reg) * MAX_SRC_WIDTH
                       + int'(cnt_reg[0] ? u2_reg : u1_reg));

    eqc_image_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (src_pixel),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cord_start = (state_reg == ST_VEC1) || (state_reg == ST_VEC2);
    assign cord_x     = (state_reg == ST_VEC2) ? r_reg : px_reg;
    assign cord_y     = (state_reg == ST_VEC2) ? pz_reg : py_reg;

    eqc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .x_in    (cord_x),
        .y_in    (cord_y),
        .stat    (cord_stat),
        .z_out   (cord_z),
        .mag_out (cord_mag)
    );

    always_comb
    begin
        if (cord_z > ANG_PI)
            theta_sat = ANG_PI;
        else if (cord_z < -ANG_PI)
            theta_sat = -ANG_PI;
        else
            theta_sat = cord_z;
        if (cord_z > ANG_HALF_PI)
            phi_sat = ANG_HALF_PI;
        else if (cord_z < -ANG_HALF_PI)
            phi_sat = -ANG_HALF_PI;
        else
            phi_sat = cord_z;
    end

    assign scale_prod = 48'(unsigned'(cord_mag)) * 48'(INV_GAIN);
    assign theta_off  = unsigned'(theta_reg + ANG_PI);
    assign phi_off    = unsigned'(ANG_PI - (phi_reg <<< 1));
    assign map_prod   = 39'(fs_reg) * 39'((state_reg == ST_MAPU) ? theta_off : phi_off);

    assign u_int  = uq_reg[17:8];
    assign v_int  = vq_reg[17:8];
    assign u1_c   = (u_int > 10'(w_reg - 1'b1)) ? (w_reg - 1'b1) : SRC_W_W'(u_int);
    assign v1_c   = (v_int > 10'(h_reg - 1'b1)) ? (h_reg - 1'b1) : SRC_H_W'(v_int);
    assign u2_c   = (u1_c + 1'b1 > w_reg - 1'b1) ? (w_reg - 1'b1) : (u1_c + 1'b1);
    assign v2_c   = (9'(v1_c) + 9'd1 > 9'(h_reg) - 9'd1) ? (h_reg - 1'b1) : (v1_c + 1'b1);
    assign s_diff = uq_reg - {u1_c, 8'd0};
    assign t_diff = vq_reg - {1'b0, v1_c, 8'd0};

    assign ws       = cnt_reg[0] ? s_reg : (9'd256 - s_reg);
    assign wt       = cnt_reg[1] ? t_reg : (9'd256 - t_reg);
    assign wgt_next = 17'(18'(ws) * 18'(wt));

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            color_next[ch*8 +: 8] = (acc_reg[ch][ACC_W-1:16] > 9'd255) ? 8'd255
                                    : acc_reg[ch][23:16];
        end
    end

    assign cx_sum = 9'(fi_reg) + 9'(face_off_x(face_reg)) * 9'(fs_reg);
    assign cy_sum = 9'(fj_reg) + 9'(face_off_y(face_reg)) * 9'(fs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wcfg_reg      <= RST_SRC_WIDTH;
            hcfg_reg      <= RST_SRC_HEIGHT;
            w_reg         <= '0;
            h_reg         <= '0;
            fs_reg        <= '0;
            face_reg      <= '0;
            fi_reg        <= '0;
            fj_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
            r_reg         <= '0;
            theta_reg     <= '0;
            phi_reg       <= '0;
            uq_reg        <= '0;
            vq_reg        <= '0;
            u1_reg        <= '0;
            u2_reg        <= '0;
            v1_reg        <= '0;
            v2_reg        <= '0;
            s_reg         <= '0;
            t_reg         <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            wgt_reg       <= '0;
            for (int ch = 0; ch < 4; ch++)
                acc_reg[ch] <= '0;
            out_valid_reg <= 1'b0;
            cross_x_reg   <= '0;
            cross_y_reg   <= '0;
            color_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SRC_WIDTH:  wcfg_reg <= cfg_data;
                    CFG_SRC_HEIGHT: hcfg_reg <= cfg_data[SRC_H_W-1:0];
                endcase
            end

            if (out_valid_reg && !out_stall && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (action == ACT_SAMPLE) && sample_ok)
                    begin
                        w_reg     <= w_eff;
                        h_reg     <= h_eff;
                        fs_reg    <= fs_eff;
                        face_reg  <= face;
                        fi_reg    <= face_i;
                        fj_reg    <= face_j;
                        px_reg    <= {{3{px_s[8]}}, px_s, 20'd0};
                        py_reg    <= {{3{py_s[8]}}, py_s, 20'd0};
                        pz_reg    <= {{3{pz_s[8]}}, pz_s, 20'd0};
                        state_reg <= ST_VEC1;
                    end
                end
                ST_VEC1:
                    state_reg <= ST_WAIT1;
                ST_WAIT1:
                begin
                    if (cord_stat.done)
                    begin
                        theta_reg <= theta_sat;
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    r_reg     <= signed'(scale_prod[47:16]);
                    state_reg <= ST_VEC2;
                end
                ST_VEC2:
                    state_reg <= ST_WAIT2;
                ST_WAIT2:
                begin
                    if (cord_stat.done)
                    begin
                        phi_reg   <= phi_sat;
                        state_reg <= ST_MAPU;
                    end
                end
                ST_MAPU:
                begin
                    uq_reg    <= map_prod[38:21];
                    state_reg <= ST_MAPV;
                end
                ST_MAPV:
                begin
                    vq_reg    <= {1'b0, map_prod[38:22]};
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    u1_reg    <= u1_c;
                    u2_reg    <= u2_c;
                    v1_reg    <= v1_c;
                    v2_reg    <= v2_c;
                    s_reg     <= (s_diff > 18'd256) ? 9'd256 : s_diff[8:0];
                    t_reg     <= (t_diff > 18'd256) ? 9'd256 : t_diff[8:0];
                    for (int ch = 0; ch < 4; ch++)
                        acc_reg[ch] <= ACC_W'(32768);
                    cnt_reg   <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= ST_FETCH;
                end
                ST_FETCH:
                begin
                    if (pend_reg)
                    begin
                        for (int ch = 0; ch < 4; ch++)
                            acc_reg[ch] <= acc_reg[ch]
                                + ACC_W'(mem_rdata[ch*8 +: 8]) * ACC_W'(wgt_reg);
                    end
                    if (cnt_reg[2])
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        wgt_reg  <= wgt_next;
                        pend_reg <= 1'b1;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        cross_x_reg   <= cx_sum[7:0];
                        cross_y_reg   <= cy_sum[7:0];
                        color_reg     <= color_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;
    assign color     = color_reg;

    `EQC_ASSERT_NEXT(a_out_from_final, clk, rst_n, !out_valid_reg, !out_valid_reg || ($past(state_reg) == ST_OUT))
    `EQC_ASSERT_SAME(a_cordic_idle, clk, rst_n, state_reg == ST_IDLE, !cord_stat.busy)
    `EQC_ASSERT_NEXT(a_load_single, clk, rst_n, accept && (action == ACT_LOAD), state_reg == ST_IDLE)
    `EQC_ASSERT_SAME(a_fetch_cnt, clk, rst_n, state_reg == ST_FETCH, cnt_reg <= 3'd4)

endmodule

// ===== dv/tb_equirect_to_cubemap_sampler_core.sv =====
// Self-checking testbench for the equirectangular to cube map sampler core: random
// load and sample beats under gaps and stalls, checked against a fixed-point predictor.
// Depends on eqc_pkg and equirect_to_cubemap_sampler_core.
module tb_equirect_to_cubemap_sampler_core;
    import eqc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAXW = DEF_MAX_SRC_WIDTH;
    localparam int  MAXH = DEF_MAX_SRC_HEIGHT;
    localparam int  STEPS = DEF_CORDIC_STEPS;
    localparam longint PI_A = 64'sd1073741824;
    localparam longint HALF_PI_A = 64'sd536870912;
    localparam longint CYCLE_LIMIT = 3000000;

    localparam longint ARCTAN [0:23] = '{
        268435456, 158466703, 83729454, 42502380, 21333666, 10677233,
        5339919, 2670123, 1335082, 667543, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608,
        1304, 652, 326, 163, 81, 41};

    typedef struct {
        logic        act;
        logic [7:0]  sx;
        logic [6:0]  sy;
        logic [31:0] pix;
        logic [2:0]  fc;
        logic [5:0]  fi;
        logic [5:0]  fj;
    } beat_t;

    typedef struct {
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [31:0] col;
    } texel_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  src_x;
    logic [6:0]  src_y;
    logic [31:0] src_pixel;
    logic [2:0]  face;
    logic [5:0]  face_i;
    logic [5:0]  face_j;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  cross_x;
    logic [7:0]  cross_y;
    logic [31:0] color;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [SRC_W_W-1:0] cfg_data;

    equirect_to_cubemap_sampler_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .src_x     (src_x),
        .src_y     (src_y),
        .src_pixel (src_pixel),
        .face      (face),
        .face_i    (face_i),
        .face_j    (face_j),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cross_x   (cross_x),
        .cross_y   (cross_y),
        .color     (color),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    beat_t       pending_beats [$];
    texel_out_t  expected_pixels [$];
    logic [31:0] image_copy [0:MAXW*MAXH-1];
    bit          loaded [0:MAXW*MAXH-1];
    int unsigned model_w = RST_SRC_WIDTH;
    int unsigned model_h = RST_SRC_HEIGHT;
    int          errors = 0;
    int          n_loads = 0;
    int          n_samples = 0;
    int          n_checked = 0;
    int          n_accepted = 0;
    bit          hold_sender = 0;
    longint      cycles = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint cordic_atan2(input longint xi, input longint yi,
                                            output longint mag);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint t;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI_A;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI_A;
            end
        end
        for (int k = 0; k < STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[k];
            end
            else if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[k];
            end
        end
        mag = (x < 0) ? 0 : x;
        return z;
    endfunction

    function automatic int unsigned eff_width(input int unsigned w);
        return (w < 4) ? 4 : ((w > MAXW) ? MAXW : w);
    endfunction

    function automatic int unsigned eff_height(input int unsigned h);
        return (h < 1) ? 1 : ((h > MAXH) ? MAXH : h);
    endfunction

    function automatic bit sample_cube_pixel(input beat_t b, output texel_out_t r);
        int unsigned w;
        int unsigned h;
        int unsigned fs;
        longint a;
        longint bb;
        longint o;
        longint px;
        longint py;
        longint pz;
        longint mag;
        longint rad;
        longint theta;
        longint phi;
        longint uq;
        longint vq;
        longint u1;
        longint v1;
        longint u2;
        longint v2;
        longint s;
        longint t;
        longint acc;
        logic [31:0] ta;
        logic [31:0] tb;
        logic [31:0] tc;
        logic [31:0] td;
        int unsigned ox;
        int unsigned oy;
        w = eff_width(model_w);
        h = eff_height(model_h);
        fs = w >> 2;
        if (b.fc > 5 || b.fi >= fs || b.fj >= fs)
            return 0;
        a = 2 * longint'(b.fi) - fs;
        bb = 2 * longint'(b.fj) - fs;
        o = fs;
        case (b.fc)
            3'd0:
            begin
                px = -o; py = a; pz = bb; ox = 1; oy = 3;
            end
            3'd1:
            begin
                px = a; py = -o; pz = -bb; ox = 0; oy = 1;
            end
            3'd2:
            begin
                px = o; py = a; pz = -bb; ox = 1; oy = 1;
            end
            3'd3:
            begin
                px = -a; py = o; pz = -bb; ox = 2; oy = 1;
            end
            3'd4:
            begin
                px = bb; py = a; pz = o; ox = 1; oy = 0;
            end
            default:
            begin
                px = -bb; py = a; pz = -o; ox = 1; oy = 2;
            end
        endcase
        px = px <<< DIR_SHIFT;
        py = py <<< DIR_SHIFT;
        pz = pz <<< DIR_SHIFT;
        theta = cordic_atan2(px, py, mag);
        rad = (mag * 39797) >> 16;
        phi = cordic_atan2(rad, pz, mag);
        if (theta > PI_A) theta = PI_A;
        if (theta < -PI_A) theta = -PI_A;
        if (phi > HALF_PI_A) phi = HALF_PI_A;
        if (phi < -HALF_PI_A) phi = -HALF_PI_A;
        uq = (longint'(fs) * (theta + PI_A)) >> 21;
        vq = (longint'(fs) * (PI_A - 2 * phi)) >> 22;
        u1 = ((uq >> 8) > w - 1) ? w - 1 : (uq >> 8);
        v1 = ((vq >> 8) > h - 1) ? h - 1 : (vq >> 8);
        u2 = (u1 + 1 > w - 1) ? w - 1 : u1 + 1;
        v2 = (v1 + 1 > h - 1) ? h - 1 : v1 + 1;
        s = (uq - u1 * 256 > 256) ? 256 : uq - u1 * 256;
        t = (vq - v1 * 256 > 256) ? 256 : vq - v1 * 256;
        ta = image_copy[v1 * MAXW + u1];
        tb = image_copy[v1 * MAXW + u2];
        tc = image_copy[v2 * MAXW + u1];
        td = image_copy[v2 * MAXW + u2];
        for (int ch = 0; ch < 4; ch++)
        begin
            acc = longint'(ta[ch*8 +: 8]) * (256 - s) * (256 - t)
                + longint'(tb[ch*8 +: 8]) * s * (256 - t)
                + longint'(tc[ch*8 +: 8]) * (256 - s) * t
                + longint'(td[ch*8 +: 8]) * s * t + 32768;
            acc = acc >> 16;
            r.col[ch*8 +: 8] = (acc > 255) ? 8'hFF : acc[7:0];
        end
        r.cx = 8'(b.fi + ox * fs);
        r.cy = 8'(b.fj + oy * fs);
        return 1;
    endfunction

    // driver: bursts and gaps, hold a beat until accepted
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        beat_t      cur;
        beat_t      nxt;
        texel_out_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_LOAD;
            src_x <= '0;
            src_y <= '0;
            src_pixel <= '0;
            face <= '0;
            face_i <= '0;
            face_j <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                n_accepted++;
                cur = '{action, src_x, src_y, src_pixel, face, face_i, face_j};
                if (cur.act == ACT_LOAD)
                begin
                    image_copy[{cur.sy, cur.sx}] = cur.pix;
                    n_loads++;
                end
                else if (sample_cube_pixel(cur, res))
                begin
                    expected_pixels.push_back(res);
                    n_samples++;
                end
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0 && !hold_sender)
                begin
                    nxt = pending_beats.pop_front();
                    action <= nxt.act;
                    src_x <= nxt.sx;
                    src_y <= nxt.sy;
                    src_pixel <= nxt.pix;
                    face <= nxt.fc;
                    face_i <= nxt.fi;
                    face_j <= nxt.fj;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern with one long hold
    int  hold_count = 0;
    bit  hold_done = 0;
    int  stall_mode = 0;
    int  mode_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (!hold_done && n_accepted >= 170 && hold_count == 0)
                hold_count = 600;
            if (hold_count > 0)
            begin
                hold_count--;
                if (hold_count == 0)
                    hold_done = 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        texel_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected beat x=%0d y=%0d color=%h", $time,
                         cross_x, cross_y, color);
                errors++;
            end
            else
            begin
                e = expected_pixels.pop_front();
                n_checked++;
                if (cross_x !== e.cx)
                begin
                    $display("%0t: cross_x expected %0d actual %0d", $time, e.cx, cross_x);
                    errors++;
                end
                if (cross_y !== e.cy)
                begin
                    $display("%0t: cross_y expected %0d actual %0d", $time, e.cy, cross_y);
                    errors++;
                end
                if (color !== e.col)
                begin
                    $display("%0t: color expected %h actual %h", $time, e.col, color);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input int unsigned val);
        cfg_index <= idx;
        cfg_data <= SRC_W_W'(val);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_SRC_WIDTH)
            model_w = val & 9'h1FF;
        else
            model_h = val & 8'hFF;
        cfg_valid <= 1'b0;
    endtask

    task automatic push_load(input int x, input int y, input logic [31:0] p);
        beat_t b;
        b = '{ACT_LOAD, 8'(x), 7'(y), p, 3'd0, 6'd0, 6'd0};
        pending_beats.push_back(b);
        loaded[y * MAXW + x] = 1;
    endtask

    task automatic push_sample(input int f, input int i, input int j);
        beat_t b;
        b = '{ACT_SAMPLE, 8'($urandom), 7'($urandom), $urandom, 3'(f), 6'(i), 6'(j)};
        pending_beats.push_back(b);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (80) @(posedge clk);
    endtask

    // config, then fill the area a sample can read, then directed beats if asked, then random beats
    task automatic run_phase(input int unsigned w, input int unsigned h, input int n,
                             input bit directed);
        int unsigned ew;
        int unsigned eh;
        int unsigned fs;
        int unsigned xmax;
        int unsigned ymax;
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        ew = eff_width(w & 9'h1FF);
        eh = eff_height(h & 8'hFF);
        fs = ew >> 2;
        xmax = (ew - 1 < 4 * fs) ? ew - 1 : 4 * fs;
        ymax = (eh - 1 < 2 * fs) ? eh - 1 : 2 * fs;
        for (int y = 0; y <= ymax; y++)
            for (int x = 0; x <= xmax; x++)
                if (!loaded[y * MAXW + x])
                    push_load(x, y, $urandom);
        if (directed)
        begin
            push_load(0, 0, 32'h0000_0000);
            push_load(1, 0, 32'hFFFF_FFFF);
            push_load(255, 127, 32'hFFFF_FFFF);
            push_load(xmax, ymax, 32'h0000_0000);
            for (int f = 0; f < 8; f++)
                push_sample(f, 0, 0);
            push_sample(0, fs - 1, fs - 1);
            push_sample(2, fs - 1, 0);
            push_sample(4, fs / 2, fs / 2);
            push_sample(5, fs / 2, fs / 2);
            push_sample(3, 0, fs - 1);
            push_sample(1, fs, 0);
            push_sample(1, 0, fs);
            push_sample(2, 63, 63);
        end
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    push_load($urandom_range(0, 255), $urandom_range(0, 127), $urandom);
                2:
                    push_sample($urandom_range(0, 7), $urandom_range(0, 63),
                                $urandom_range(0, 63));
                default:
                    push_sample($urandom_range(0, 5), $urandom_range(0, fs - 1),
                                $urandom_range(0, fs - 1));
            endcase
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SRC_WIDTH;
        cfg_data = '0;
        for (int a = 0; a < MAXW * MAXH; a++)
        begin
            loaded[a] = 0;
            image_copy[a] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_phase(16, 9, 40, 1);
        run_phase(511, 1, 50, 0);
        run_phase(0, 0, 30, 0);
        run_phase(4, 255, 40, 0);
        run_phase(12, 3, 40, 0);
        run_phase(20, 6, 40, 0);
        hold_sender = 1;
        run_phase(20, 6, 0, 0);
        hold_sender = 0;
        run_phase(100, 1, 40, 0);
        $display("covered %0d loads and %0d valid samples, %0d results checked",
                 n_loads, n_samples, n_checked);
        $display("widths 0..511 and heights 0..255 incl. saturation, long output hold");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
